[hdl/plst_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// plst_pkg
// Shared types and constants for the positional list store: request and
// status codes, controller states, and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package plst_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int POS_W        = 7;
  localparam int DATA_W       = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_FETCH,
    S_SH_RD,
    S_SH_WR,
    S_PUT,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_POS,
    RD_PREV,
    RD_NEXT
  } rd_sel_t;

  typedef enum logic {
    WR_SHIFT,
    WR_VALUE
  } wr_sel_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_COUNT,
    IDX_POS,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef struct packed {
    logic    load_req;
    logic    res_load;
    logic    got_load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    idx_op_t idx_op;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_load;
  } plst_cmd_t;

  typedef struct packed {
    op_t     op;
    status_t chk;
    logic    ins_at_end;
    logic    ins_last;
    logic    rem_at_end;
    logic    rem_last;
    logic    out_free;
  } plst_stat_t;

endpackage
`default_nettype wire

[hdl/plst_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// plst_ctrl
// Controller for the positional list store. Sequences the check, the
// element fetch, the one-element-at-a-time shift through the store and the
// hand-off of the result word.
// ----------------------------------------------------------------------------
module plst_ctrl
  import plst_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire plst_stat_t stat,
  output plst_cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.res_load = 1'b1;
        if (stat.chk != ST_OK) begin
          state_next = S_DONE;
        end else if (stat.op == OP_INSERT) begin
          cmd.idx_op = IDX_COUNT;
          state_next = stat.ins_at_end ? S_PUT : S_SH_RD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_POS;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.got_load = 1'b1;
        if (stat.op == OP_READ) begin
          state_next = S_DONE;
        end else if (stat.rem_at_end) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.idx_op = IDX_POS;
          state_next = S_SH_RD;
        end
      end
      S_SH_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = (stat.op == OP_INSERT) ? RD_PREV : RD_NEXT;
        state_next = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_SHIFT;
        if (stat.op == OP_INSERT) begin
          cmd.idx_op = IDX_DEC;
          state_next = stat.ins_last ? S_PUT : S_SH_RD;
        end else begin
          cmd.idx_op = IDX_INC;
          if (stat.rem_last) begin
            cmd.cnt_dec = 1'b1;
            state_next  = S_DONE;
          end else begin
            state_next = S_SH_RD;
          end
        end
      end
      S_PUT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_VALUE;
        cmd.cnt_inc = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        // Wait here until the output register can take the word.
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[hdl/plst_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// plst_dp
// Datapath for the positional list store: request registers, the element
// memory with its registered read port, the list length, the shift index,
// the status check and the output register.
// ----------------------------------------------------------------------------
module plst_dp
  import plst_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
)
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire plst_cmd_t                cmd,
  output plst_stat_t                    stat,
  input  wire logic [1:0]               op,
  input  wire logic [POS_W-1:0]         position,
  input  wire logic signed [DATA_W-1:0] value,
  input  wire logic                     out_stall,
  output logic                          out_valid,
  output logic [1:0]                    status,
  output logic signed [DATA_W-1:0]      value_out
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 2;

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rdata;

  op_t               op_r;
  logic [POS_W-1:0]  pos_r;
  logic [DATA_W-1:0] val_r;
  status_t           res_status;
  logic [DATA_W-1:0] got;
  logic [AW-1:0]     idx;
  logic [CW-1:0]     count;
  status_t           out_status;
  logic [DATA_W-1:0] out_value;

  logic [CMPW-1:0]   pos_x;
  logic [CMPW-1:0]   count_x;
  logic [CMPW-1:0]   idx_x;
  logic [AW-1:0]     pos_a;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  status_t           chk;

  assign pos_x   = CMPW'(pos_r);
  assign count_x = CMPW'(count);
  assign idx_x   = CMPW'(idx);
  assign pos_a   = pos_x[AW-1:0];

  always_comb begin
    case (op_r)
      OP_INSERT: begin
        if (pos_x > count_x) begin
          chk = ST_BADPOS;
        end else if (count_x == CMPW'(CAPACITY)) begin
          chk = ST_FULL;
        end else begin
          chk = ST_OK;
        end
      end
      OP_REMOVE, OP_READ: begin
        if (count == '0) begin
          chk = ST_EMPTY;
        end else if (pos_x >= count_x) begin
          chk = ST_BADPOS;
        end else begin
          chk = ST_OK;
        end
      end
      default: begin
        chk = ST_BADPOS;
      end
    endcase
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_PREV: rd_addr = idx - AW'(1);
      RD_NEXT: rd_addr = idx + AW'(1);
      default: rd_addr = pos_a;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      WR_VALUE: begin
        wr_addr = pos_a;
        wr_data = val_r;
      end
      default: begin
        wr_addr = idx;
        wr_data = rdata;
      end
    endcase
  end

  always_comb begin
    stat.op         = op_r;
    stat.chk        = chk;
    stat.ins_at_end = (count_x == pos_x);
    stat.ins_last   = (idx_x == pos_x + CMPW'(1));
    stat.rem_at_end = (pos_x + CMPW'(1) >= count_x);
    stat.rem_last   = (idx_x + CMPW'(2) >= count_x);
    stat.out_free   = !out_valid || !out_stall;
  end

  // Element memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r  <= op_t'(op);
      pos_r <= position;
      val_r <= value;
    end
    if (cmd.res_load) begin
      res_status <= chk;
      got        <= '0;
    end else if (cmd.got_load) begin
      got <= rdata;
    end
    case (cmd.idx_op)
      IDX_COUNT: idx <= count[AW-1:0];
      IDX_POS:   idx <= pos_a;
      IDX_INC:   idx <= idx + AW'(1);
      IDX_DEC:   idx <= idx - AW'(1);
      default:   idx <= idx;
    endcase
    if (cmd.out_load) begin
      out_status <= res_status;
      out_value  <= got;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status    = out_status;
  assign value_out = out_value;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_x <= CMPW'(CAPACITY))
    else $error("list length exceeds the store size");

  a_inc_room: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> count_x < CMPW'(CAPACITY))
    else $error("insert committed into a full store");

  a_dec_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_dec |-> count != '0)
    else $error("remove committed on an empty list");

  a_rd_inside: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> CMPW'(rd_addr) < count_x)
    else $error("memory read outside the live list");

  a_wr_inside: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> CMPW'(wr_addr) <= count_x)
    else $error("memory write beyond the end of the list");
`endif

endmodule
`default_nettype wire

[hdl/positional_list_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of signed 32-bit values in a bounded store, with insert,
// remove and read at a position. Later elements are shifted to keep order.
//
//   Channel  Handshake            Word
//   in       in_valid/in_stall    op, position, value
//   out      out_valid/out_stall  status, value_out
//
// One request is in flight at a time. A read fetches the element at the
// position; an insert shifts the elements from the position onward up one
// place and a remove shifts the elements after it down one place. Each
// moved element is read from the store and then written to its new place.
// Reset empties the list; the store contents stay undefined until written.
// A stalled output word holds while the next request is already accepted.
// ----------------------------------------------------------------------------
module positional_list_store
  import plst_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
)
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               op,
  input  wire logic [POS_W-1:0]         position,
  input  wire logic signed [DATA_W-1:0] value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [1:0]                    status,
  output logic signed [DATA_W-1:0]      value_out
);

  plst_cmd_t  cmd;
  plst_stat_t stat;

  plst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  plst_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .op        (op),
    .position  (position),
    .value     (value),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .status    (status),
    .value_out (value_out)
  );

endmodule
`default_nettype wire

[verif/positional_list_store_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store_tb
// Self-checking bench for the positional list store. A shadow copy of the
// list is updated for every accepted request and gives the status and value
// that the block must return. Results are compared in order, field by field.
// Directed cases cover the empty, full and out-of-range cases and the value
// extremes. Random traffic then moves the list between empty and full, under
// random idling on both channels, a long output hold-off and a burst with no
// idling at all.
// ----------------------------------------------------------------------------
module positional_list_store_tb;
  import plst_pkg::*;

  localparam int          CAP              = CAPACITY_DEF;
  localparam int          POS_MAX          = (1 << POS_W) - 1;
  localparam int          SINK_HOLD_CYCLES = 400;
  localparam int          DRAIN_CYCLES     = 200;
  localparam int unsigned LIMIT_CYCLES     = 1_000_000;

  typedef struct {
    status_t           st;
    logic [DATA_W-1:0] val;
  } list_resp_t;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  logic [1:0]               op        = OP_INSERT;
  logic [POS_W-1:0]         position  = '0;
  logic signed [DATA_W-1:0] value     = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] value_out;

  // Shadow of the list contents and the answers still owed by the block.
  logic signed [DATA_W-1:0] shadow_list[$];
  list_resp_t               awaited_resp[$];
  list_resp_t               head_resp;

  logic        send_gaps = 1'b1;
  logic        sink_gaps = 1'b1;
  logic        sink_held = 1'b0;
  event        start_sink_hold;

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned requests_sent  = 0;
  int unsigned results_seen   = 0;
  int unsigned peak_len       = 0;
  int unsigned status_hits[4] = '{0, 0, 0, 0};

  positional_list_store #(
    .CAPACITY(CAP)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .position (position),
    .value    (value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .value_out(value_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, awaited_resp.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Applies one request to the shadow list and returns the expected answer.
  function automatic list_resp_t apply_request(op_t o, logic [POS_W-1:0] p,
                                               logic signed [DATA_W-1:0] v);
    list_resp_t  r;
    int unsigned n;
    n     = shadow_list.size();
    r.st  = ST_BADPOS;
    r.val = '0;
    case (o)
      OP_INSERT: begin
        if (p > n) r.st = ST_BADPOS;
        else if (n >= CAP) r.st = ST_FULL;
        else begin
          shadow_list.insert(p, v);
          r.st = ST_OK;
        end
      end
      OP_REMOVE, OP_READ: begin
        if (n == 0) r.st = ST_EMPTY;
        else if (p >= n) r.st = ST_BADPOS;
        else begin
          r.st  = ST_OK;
          r.val = shadow_list[p];
          if (o == OP_REMOVE) shadow_list.delete(p);
        end
      end
      default: r.st = ST_BADPOS;
    endcase
    return r;
  endfunction

  function automatic logic [POS_W-1:0] pick_position(op_t o);
    int unsigned n;
    int unsigned roll;
    n    = shadow_list.size();
    roll = $urandom_range(99);
    if (roll < 6 || o == OP_NONE) return POS_W'($urandom_range(POS_MAX));
    if (roll < 12) return POS_W'(n);
    if (o == OP_INSERT) return POS_W'($urandom_range(n));
    if (n == 0) return '0;
    return POS_W'($urandom_range(n - 1));
  endfunction

  function automatic logic signed [DATA_W-1:0] random_value();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) return 32'sh8000_0000;
    if (roll < 10) return 32'sh7fff_ffff;
    if (roll < 13) return -1;
    if (roll < 15) return 0;
    return $urandom();
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("MISMATCH cycle %0d: %s", cycle_count, what);
  endtask

  // Offers one word and holds it until accepted; valid stays high afterwards
  // so that back-to-back words need no extra edge.
  task automatic send_request(input op_t o, input logic [POS_W-1:0] p,
                              input logic signed [DATA_W-1:0] v);
    list_resp_t r;
    @(negedge clk);
    while (send_gaps && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    position <= p;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = apply_request(o, p, v);
    awaited_resp.push_back(r);
    status_hits[r.st]++;
    requests_sent++;
    if (shadow_list.size() > peak_len) peak_len = shadow_list.size();
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_all_answered();
    idle_input();
    while (awaited_resp.size() != 0) @(posedge clk);
  endtask

  task automatic random_requests(input int unsigned count, input int unsigned insert_pct);
    int unsigned roll;
    op_t         o;
    for (int unsigned k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      if (roll < 3) o = OP_NONE;
      else if (roll < 3 + insert_pct * 97 / 100) o = OP_INSERT;
      else if ($urandom_range(1) == 1) o = OP_REMOVE;
      else o = OP_READ;
      send_request(o, pick_position(o), random_value());
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (awaited_resp.size() == 0) begin
        report_mismatch($sformatf("unexpected word status=%0d value_out=%0d",
                                  status, value_out));
      end else begin
        head_resp = awaited_resp.pop_front();
        if (status !== head_resp.st)
          report_mismatch($sformatf("status %0d, expected %s", status,
                                    head_resp.st.name()));
        if (value_out !== head_resp.val)
          report_mismatch($sformatf("value_out %0h, expected %0h", value_out,
                                    head_resp.val));
      end
    end
  end

  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (sink_held) out_stall <= 1'b1;
    else out_stall <= sink_gaps && ($urandom_range(99) < 30);
  end

  // The hold-off is counted here so the sender keeps running meanwhile.
  always begin
    @(start_sink_hold);
    sink_held = 1'b1;
    repeat (SINK_HOLD_CYCLES) @(posedge clk);
    sink_held = 1'b0;
  end

  task automatic test_edge_cases();
    send_request(OP_READ, 0, 0);
    send_request(OP_REMOVE, POS_W'(POS_MAX), 0);
    send_request(OP_INSERT, 1, 5);
    send_request(OP_INSERT, POS_W'(POS_MAX), 5);
    send_request(OP_NONE, 0, 0);
    send_request(OP_INSERT, 0, 32'sh8000_0000);
    send_request(OP_INSERT, 1, 32'sh7fff_ffff);
    send_request(OP_INSERT, 0, -1);
    send_request(OP_INSERT, 1, 0);
    for (int k = 0; k < 4; k++) send_request(OP_READ, POS_W'(k), 0);
    send_request(OP_READ, 4, 0);
    send_request(OP_READ, POS_W'(POS_MAX), 0);
    send_request(OP_REMOVE, 3, 0);
    send_request(OP_REMOVE, 0, 0);
    send_request(OP_INSERT, 2, 32'sh5555_5555);
    send_request(OP_REMOVE, 1, 0);
    send_request(OP_READ, 1, 0);
    send_request(OP_NONE, POS_W'(POS_MAX), -1);
    send_request(OP_REMOVE, 0, 0);
    send_request(OP_REMOVE, 0, 0);
    send_request(OP_READ, 0, 0);
  endtask

  // Fills the store at random positions, then hits it with a full store and
  // with positions past the end, which must be reported as invalid first.
  task automatic test_fill_and_overflow();
    while (shadow_list.size() < CAP)
      send_request(OP_INSERT, POS_W'($urandom_range(shadow_list.size())), random_value());
    send_request(OP_INSERT, POS_W'(CAP), 1);
    send_request(OP_INSERT, 0, 2);
    send_request(OP_INSERT, POS_W'(CAP + 1), 3);
    send_request(OP_INSERT, POS_W'(POS_MAX), 4);
    send_request(OP_READ, POS_W'(CAP - 1), 0);
    send_request(OP_READ, POS_W'(CAP), 0);
    send_request(OP_REMOVE, POS_W'(CAP - 1), 0);
    send_request(OP_INSERT, POS_W'(CAP - 1), random_value());
  endtask

  task automatic test_drain_to_empty();
    while (shadow_list.size() > 0)
      send_request(OP_REMOVE, POS_W'($urandom_range(shadow_list.size() - 1)), 0);
    send_request(OP_REMOVE, 0, 0);
  endtask

  task automatic test_output_backpressure();
    -> start_sink_hold;
    random_requests(30, 60);
  endtask

  task automatic test_random_mix();
    random_requests(250, 70);
    random_requests(250, 30);
    random_requests(250, 60);
    random_requests(250, 45);
  endtask

  task automatic test_burst_no_idle();
    send_gaps = 1'b0;
    sink_gaps = 1'b0;
    random_requests(150, 50);
    wait_all_answered();
    send_gaps = 1'b1;
    sink_gaps = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_edge_cases();
    test_fill_and_overflow();
    wait_all_answered();
    test_drain_to_empty();
    test_output_backpressure();
    test_random_mix();
    test_burst_no_idle();
    wait_all_answered();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d requests and %0d result words in %0d cycles, longest list %0d of %0d.",
             requests_sent, results_seen, cycle_count, peak_len, CAP);
    $display("Answers: %0d ok, %0d empty list, %0d invalid position, %0d store full.",
             status_hits[ST_OK], status_hits[ST_EMPTY], status_hits[ST_BADPOS],
             status_hits[ST_FULL]);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
